// ----- hw/rtl/bfdh_pkg.sv -----
// ----------------------------------------------------------------------------
// bfdh_pkg
// Shared types and constants of the double-hashing bloom filter.
// ----------------------------------------------------------------------------
package bfdh_pkg;

	localparam int HASH_W = 64;
	localparam int CFG_W  = 17;
	localparam int BC_W   = 17;
	localparam int HC_W   = 5;

	// configuration register indexes
	localparam logic CFG_BIT_COUNT  = 1'b0;
	localparam logic CFG_HASH_COUNT = 1'b1;

	// request codes
	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_QUERY  = 1'b1;

	localparam logic [BC_W-1:0] BIT_COUNT_RST  = 17'd65536;
	localparam logic [HC_W-1:0] HASH_COUNT_RST = 5'd7;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_START,
		ST_MOD,
		ST_CHECK,
		ST_DONE
	} state_t;

endpackage

// ----- hw/rtl/bloom_filter_double_hash.sv -----
// ----------------------------------------------------------------------------
// bloom_filter_double_hash
// Bloom filter over a bit array with double hashing; positions are
// (hash_a + i*hash_b) mod 2^64 mod bit_count, reduced by a serial remainder.
//
// channel | signals                                  | direction
// in      | in_valid, in_ready, req_type, hash_a/_b  | item in
// out     | out_valid, out_ready, maybe_present      | item out, queries only
// cfg     | cfg_we, cfg_index, cfg_data              | register write
//
// each position runs a start step, one remainder step per dividend bit and an
// array access, and a query adds a check of the read bit; a query stops at the
// first clear bit it meets.
// after reset the array is cleared one address at a time, no item is taken then.
// one item is in work at a time; a new item is taken while a result waits,
// and a query finishing behind a waiting result stalls until it is taken.
// ----------------------------------------------------------------------------
module bloom_filter_double_hash #(
	parameter int MAX_BITS   = 65536,
	parameter int MAX_HASHES = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         req_type,
	input  logic [bfdh_pkg::HASH_W-1:0]  hash_a,
	input  logic [bfdh_pkg::HASH_W-1:0]  hash_b,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         maybe_present,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [bfdh_pkg::CFG_W-1:0]   cfg_data
);

	import bfdh_pkg::*;

	localparam int AW = $clog2(MAX_BITS);
	localparam int CW = $clog2(MAX_BITS+1);
	localparam int TW = AW + 1;
	localparam int KW = $clog2(MAX_HASHES+1);

	state_t state_q, state_d;

	logic [BC_W-1:0]   bit_count_q;
	logic [HC_W-1:0]   hash_count_q;
	logic [AW-1:0]     clr_addr_q;
	logic [HASH_W-1:0] x_q;
	logic [HASH_W-1:0] hb_q;
	logic              is_query_q;
	logic [KW-1:0]     left_q;
	logic [CW-1:0]     m_q;
	logic              res_q;
	logic              out_valid_q;
	logic              maybe_present_q;

	logic [31:0]   bc_ext;
	logic [7:0]    hc_ext;
	logic [CW-1:0] m_eff;
	logic [KW-1:0] k_eff;

	logic          accept;
	logic          last_pos;
	logic          step;
	logic          load_out;
	logic          rem_start;
	logic          rem_done;
	logic [AW-1:0] rem_val;
	logic          ram_en;
	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic          ram_wdata;
	logic          ram_rdata;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_count_q  <= BIT_COUNT_RST;
			hash_count_q <= HASH_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BIT_COUNT:  bit_count_q  <= cfg_data[BC_W-1:0];
				CFG_HASH_COUNT: hash_count_q <= cfg_data[HC_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp the registers to the usable range
	assign bc_ext = 32'(bit_count_q);
	assign hc_ext = 8'(hash_count_q);

	always_comb begin
		if (bit_count_q == '0) begin
			m_eff = CW'(1);
		end else if (bc_ext > 32'(MAX_BITS)) begin
			m_eff = CW'(MAX_BITS);
		end else begin
			m_eff = CW'(bit_count_q);
		end
		if (hash_count_q == '0) begin
			k_eff = KW'(1);
		end else if (hc_ext > 8'(MAX_HASHES)) begin
			k_eff = KW'(MAX_HASHES);
		end else begin
			k_eff = KW'(hash_count_q);
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign last_pos = (left_q == KW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		rem_start = 1'b0;
		ram_en    = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = rem_val;
		ram_wdata = 1'b1;
		step      = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				ram_en    = 1'b1;
				ram_we    = 1'b1;
				ram_addr  = clr_addr_q;
				ram_wdata = 1'b0;
				if (clr_addr_q == AW'(MAX_BITS-1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				rem_start = 1'b1;
				state_d   = ST_MOD;
			end
			ST_MOD: begin
				if (rem_done) begin
					ram_en = 1'b1;
					ram_we = (is_query_q == REQ_INSERT);
					if (is_query_q == REQ_QUERY) begin
						state_d = ST_CHECK;
					end else if (last_pos) begin
						state_d = ST_IDLE;
					end else begin
						step    = 1'b1;
						state_d = ST_START;
					end
				end
			end
			ST_CHECK: begin
				// stop at the first clear bit
				if (!ram_rdata || last_pos) begin
					state_d = ST_DONE;
				end else begin
					step    = 1'b1;
					state_d = ST_START;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q        <= hash_a;
			hb_q       <= hash_b;
			is_query_q <= req_type;
			left_q     <= k_eff;
			m_q        <= m_eff;
		end else if (step) begin
			x_q    <= x_q + hb_q;
			left_q <= left_q - KW'(1);
		end
		if (state_q == ST_CHECK) begin
			res_q <= ram_rdata;
		end
		if (load_out) begin
			maybe_present_q <= res_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign maybe_present = maybe_present_q;

	bfdh_rem #(
		.MAX_BITS (MAX_BITS)
	) u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (rem_start),
		.dividend  (x_q),
		.modulus   (m_q),
		.done      (rem_done),
		.remainder (rem_val)
	);

	bfdh_ram #(
		.WIDTH (1),
		.DEPTH (MAX_BITS)
	) u_bits (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

`ifndef ASSERT_OFF
	a_rem_done_in_mod: assert property (@(posedge clk) disable iff (!arst_n)
		rem_done |-> state_q == ST_MOD)
		else $error("remainder finished outside the wait state");

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rem_done |-> TW'(rem_val) < TW'(m_q))
		else $error("bit position not below bit count");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_START && left_q != '0)
		else $error("accepted item did not start with positions left");

	a_set_only_insert: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we && state_q != ST_CLEAR |-> is_query_q == REQ_INSERT && ram_wdata)
		else $error("array bit written outside an insert");
`endif

endmodule

// ----- hw/rtl/bfdh_ram.sv -----
// ----------------------------------------------------------------------------
// bfdh_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module bfdh_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata_q <= mem[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/bfdh_rem.sv -----
// ----------------------------------------------------------------------------
// bfdh_rem
// Bit-serial restoring remainder unit: 64-bit dividend modulo a runtime
// modulus, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module bfdh_rem #(
	parameter int MAX_BITS = 65536
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [bfdh_pkg::HASH_W-1:0]        dividend,
	input  logic [$clog2(MAX_BITS+1)-1:0]      modulus,
	output logic                               done,
	output logic [$clog2(MAX_BITS)-1:0]        remainder
);

	import bfdh_pkg::*;

	localparam int AW  = $clog2(MAX_BITS);
	localparam int CW  = $clog2(MAX_BITS+1);
	localparam int TW  = AW + 1;
	localparam int NW  = $clog2(HASH_W+1);

	logic [HASH_W-1:0] div_q;
	logic [AW-1:0]     rem_q;
	logic [CW-1:0]     mod_q;
	logic [NW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [TW-1:0] trial;
	logic [TW-1:0] mod_ext;
	logic [TW-1:0] diff;

	// shift in the next dividend bit and subtract when it fits
	assign trial   = {rem_q, div_q[HASH_W-1]};
	assign mod_ext = TW'(mod_q);
	assign diff    = trial - mod_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == NW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= dividend;
			rem_q <= '0;
			mod_q <= modulus;
			cnt_q <= NW'(HASH_W);
		end else if (busy_q) begin
			div_q <= {div_q[HASH_W-2:0], 1'b0};
			cnt_q <= cnt_q - NW'(1);
			if (trial >= mod_ext) begin
				rem_q <= diff[AW-1:0];
			end else begin
				rem_q <= trial[AW-1:0];
			end
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the double-hashing bloom filter. A software copy
// of the bit array predicts every query answer; inserts use fresh keys, queries
// mix fresh keys with keys already inserted, across several bit_count / hash_count
// settings including zero, one, the maximum and saturating values.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bfdh_pkg::*;

	localparam int MAX_BITS   = 65536;
	localparam int MAX_HASHES = 16;
	// settle time covers the longest insert, at the top probe count
	localparam int SETTLE     = 66 * MAX_HASHES + 200;
	localparam int LONG_HOLD  = 3000;
	localparam int LIMIT      = 3000000;

	class bloom_tracker;
		bit          filter_bits [MAX_BITS];
		int unsigned modulus;
		int unsigned probes;
		bit          answers_due [$];
		int          errors;
		int          inserts;
		int          queries;
		int          hits;

		function new();
			modulus = BIT_COUNT_RST;
			probes  = HASH_COUNT_RST;
		endfunction

		function void set_bit_count(logic [BC_W-1:0] v);
			if (v == 0)
				modulus = 1;
			else if (v > MAX_BITS)
				modulus = MAX_BITS;
			else
				modulus = v;
		endfunction

		function void set_hash_count(logic [HC_W-1:0] v);
			if (v == 0)
				probes = 1;
			else if (v > MAX_HASHES)
				probes = MAX_HASHES;
			else
				probes = v;
		endfunction

		function int pending();
			return answers_due.size();
		endfunction

		function void note_request(logic rt, logic [HASH_W-1:0] ha, logic [HASH_W-1:0] hb);
			logic [HASH_W-1:0] pos;
			int unsigned       idx;
			bit                all_set;
			all_set = 1'b1;
			for (int unsigned i = 0; i < probes; i++) begin
				// wraps at 2^64 before the modulus
				pos = ha + hb * HASH_W'(i);
				idx = int'(pos % HASH_W'(modulus));
				if (rt == REQ_QUERY) begin
					if (!filter_bits[idx])
						all_set = 1'b0;
				end else begin
					filter_bits[idx] = 1'b1;
				end
			end
			if (rt == REQ_QUERY) begin
				answers_due.insert(answers_due.size(), all_set);
				queries++;
				if (all_set)
					hits++;
			end else begin
				inserts++;
			end
		endfunction

		function void check_answer(logic mp);
			bit want;
			if (answers_due.size() == 0) begin
				$error("maybe_present: item with no query waiting, actual %0b", mp);
				errors++;
			end else begin
				want = answers_due.pop_front();
				if (mp !== want) begin
					$error("maybe_present mismatch: expected %0b, actual %0b", want, mp);
					errors++;
				end
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic                  req_type;
	logic [HASH_W-1:0]     hash_a;
	logic [HASH_W-1:0]     hash_b;
	logic                  out_valid;
	logic                  out_ready;
	logic                  maybe_present;
	logic                  cfg_we;
	logic                  cfg_index;
	logic [CFG_W-1:0]      cfg_data;

	bloom_tracker          sb = new();
	bit                    calm;
	int                    answered;
	int                    settings;
	longint                cycles;
	logic [2*HASH_W-1:0]   key_pool [$];

	bloom_filter_double_hash #(
		.MAX_BITS   (MAX_BITS),
		.MAX_HASHES (MAX_HASHES)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.hash_a        (hash_a),
		.hash_b        (hash_b),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.maybe_present (maybe_present),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// results are checked before the same edge's input is noted
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				sb.check_answer(maybe_present);
				answered++;
			end
			if (in_valid && in_ready)
				sb.note_request(req_type, hash_a, hash_b);
		end
	end

	// result side: short random stalls, one long hold-off to back the block up
	initial begin : sink
		bit held;
		int n;
		held = 1'b0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!calm && !held && answered >= 60) begin
				out_ready = 1'b0;
				held = 1'b1;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				out_ready = 1'b0;
				n = $urandom_range(1, 5);
				repeat (n - 1) @(negedge clk);
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	function automatic logic [HASH_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic send(input logic rt, input logic [HASH_W-1:0] ha,
			input logic [HASH_W-1:0] hb);
		int n;
		@(negedge clk);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid = 1'b0;
			n = $urandom_range(1, 5);
			repeat (n) @(negedge clk);
		end
		in_valid = 1'b1;
		req_type = rt;
		hash_a   = ha;
		hash_b   = hb;
		do @(posedge clk); while (!in_ready);
	endtask

	// sender pauses until every answer is back, then lets trailing inserts finish
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] v);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = v;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == CFG_BIT_COUNT)
			sb.set_bit_count(v);
		else
			sb.set_hash_count(v[HC_W-1:0]);
	endtask

	task automatic random_item();
		int                sel;
		logic [HASH_W-1:0] ha;
		logic [HASH_W-1:0] hb;
		logic [2*HASH_W-1:0] k;
		sel = $urandom_range(0, 9);
		if (sel < 4 || key_pool.size() == 0) begin
			ha = rand64();
			hb = ($urandom_range(0, 3) == 0) ? HASH_W'($urandom_range(0, 15)) : rand64();
			send(REQ_INSERT, ha, hb);
			key_pool.insert(key_pool.size(), {ha, hb});
			if (key_pool.size() > 64)
				void'(key_pool.pop_front());
		end else if (sel < 7) begin
			k = key_pool[$urandom_range(0, key_pool.size() - 1)];
			send(REQ_QUERY, k[2*HASH_W-1:HASH_W], k[HASH_W-1:0]);
		end else if (sel < 9) begin
			send(REQ_QUERY, rand64(), rand64());
		end else begin
			// near miss: a stored key with one bit flipped
			k = key_pool[$urandom_range(0, key_pool.size() - 1)];
			k[$urandom_range(0, 2*HASH_W-1)] ^= 1'b1;
			send(REQ_QUERY, k[2*HASH_W-1:HASH_W], k[HASH_W-1:0]);
		end
	endtask

	initial begin : stim
		logic [CFG_W-1:0] bc;
		logic [CFG_W-1:0] hc;
		int               n;
		logic [HASH_W-1:0] r;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		req_type  = REQ_INSERT;
		hash_a    = '0;
		hash_b    = '0;
		cfg_we    = 1'b0;
		cfg_index = CFG_BIT_COUNT;
		cfg_data  = '0;
		calm      = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, at the reset settings; the array clear runs first
		send(REQ_QUERY,  '0, '0);
		send(REQ_INSERT, '0, '0);
		send(REQ_QUERY,  '0, '0);
		send(REQ_QUERY,  '0, 64'd1);
		send(REQ_INSERT, '1, '1);
		send(REQ_QUERY,  '1, '1);
		send(REQ_INSERT, '1, 64'd1);
		send(REQ_QUERY,  '0, 64'd1);
		send(REQ_QUERY,  '1, 64'd1);
		send(REQ_QUERY,  64'h8000_0000_0000_0000, '0);
		r = rand64();
		send(REQ_INSERT, r, 64'h8000_0000_0000_0000);
		send(REQ_QUERY,  r, 64'h8000_0000_0000_0000);
		send(REQ_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
		send(REQ_QUERY,  64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
		send(REQ_QUERY,  64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
		send(REQ_QUERY,  64'hAAAA_AAAA_AAAA_AAAB, 64'h5555_5555_5555_5555);
		send(REQ_INSERT, 64'h0000_0000_0000_FFFF, 64'hFFFF_FFFF_FFFF_0000);
		send(REQ_QUERY,  64'h0000_0000_0000_FFFF, 64'hFFFF_FFFF_FFFF_0000);

		for (int ph = 0; ph < 9; ph++) begin
			case (ph)
				0: begin bc = 17'd0;      hc = 17'd0;  n = 20; end
				1: begin bc = 17'd1;      hc = 17'd16; n = 20; end
				2: begin bc = 17'h1FFFF;  hc = 17'd31; n = 30; end
				3: begin bc = 17'd65536;  hc = 17'd1;  n = 80; end
				4: begin
					bc = CFG_W'($urandom_range(8, 256));
					hc = CFG_W'($urandom_range(1, 8));
					n  = 80;
				end
				5: begin bc = 17'd65537;  hc = 17'd17; n = 30; end
				6: begin
					bc = CFG_W'($urandom);
					hc = CFG_W'($urandom_range(0, 31));
					n  = 80;
				end
				7: begin
					bc = CFG_W'($urandom_range(2, 4096));
					hc = CFG_W'($urandom_range(2, 6));
					n  = 80;
				end
				default: begin
					bc = CFG_W'($urandom_range(500, 3000));
					hc = 17'd4;
					n  = 80;
				end
			endcase
			drain();
			write_reg(CFG_BIT_COUNT, bc);
			write_reg(CFG_HASH_COUNT, hc);
			settings++;
			// last stretch runs at full rate on both sides
			calm = (ph == 8);
			repeat (n) random_item();
		end
		drain();

		$display("covered %0d inserts and %0d queries, %0d answered maybe-present",
			sb.inserts, sb.queries, sb.hits);
		$display("over %0d register settings incl. zero, one, maximum and saturating values",
			settings + 1);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
